[rtl/interpolation_search_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// Interpolation search engine assertion macros
// Property shorthands on clock/reset for the engine's checks.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATION_SEARCH_ENGINE_UNIT_MACROS_SVH
`define INTERPOLATION_SEARCH_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define ISE_ASSERT_IMPLY(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("search engine check failed (same cycle)");

// next-cycle implication
`define ISE_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("search engine check failed (next cycle)");

`endif

[rtl/ise_pkg.sv]
// ----------------------------------------------------------------------------
// Interpolation search engine package
// Widths, request codes and sequencer states shared by the engine files.
// ----------------------------------------------------------------------------
package ise_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = IDX_W + 1;
   localparam int DATA_W      = 32;
   localparam int NUM_W       = DATA_W + IDX_W;
   localparam int CNT_W       = $clog2(IDX_W);

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_LO,
      ST_READ_HI,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_ADDR,
      ST_COMPARE,
      ST_DONE
   } ise_state_type;

endpackage

[rtl/ise_ifs.sv]
// ----------------------------------------------------------------------------
// Interpolation search engine channels
// Valid/ready channels for requests, responses and the size register.
// ----------------------------------------------------------------------------
interface ise_req_if import ise_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [IDX_W-1:0]         entry_index;
   logic signed [DATA_W-1:0] entry_value;
   logic signed [DATA_W-1:0] search_key;

   modport source (output valid, req_type, entry_index, entry_value, search_key,
                   input ready);
   modport sink   (input valid, req_type, entry_index, entry_value, search_key,
                   output ready);
endinterface

interface ise_rsp_if import ise_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] found_index;

   modport source (output valid, found, found_index, input ready);
   modport sink   (input valid, found, found_index, output ready);
endinterface

interface ise_csr_if import ise_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] table_size;

   modport source (output valid, table_size, input ready);
   modport sink   (input valid, table_size, output ready);
endinterface

[rtl/interpolation_search_engine_unit.sv]
// ----------------------------------------------------------------------------
// Interpolation search engine
// Sorted table of signed words in an on-chip RAM, searched by interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one word per request. req_type write stores entry_value at
//             entry_index (no response); search looks up search_key.
//   rsp_ch  : one word per search: found and found_index (0 if not found).
//   csr_ch  : table_size, number of entries searched from index 0. Values
//             above the table depth count as the full table. Always ready.
// Operation:
//   A search runs probes until it ends, and it may end on the window end check.
//   A probe reads the window ends through the single RAM read port, runs one
//   32x10 multiply and a 10-step shift-subtract divider, then reads the probe
//   entry through the same port.
//   Probes per search depend on the data (1 for evenly spread values, up to
//   the table size in the worst case).
//   One request is worked on at a time; req_ch.ready is high only while idle.
// Reset:
//   table_size clears to 0; the table RAM is not cleared and entries must be
//   written before a search reads them.
// Stall:
//   The response sits in an output register; the engine goes back to idle
//   and takes further requests while it waits. A finished search holds in
//   its last state until that register is free.
// ----------------------------------------------------------------------------
`include "interpolation_search_engine_unit_macros.svh"

module interpolation_search_engine_unit import ise_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ise_req_if.sink      req_ch,
   ise_rsp_if.source    rsp_ch,
   ise_csr_if.sink      csr_ch
);

   // table RAM
   logic [DATA_W-1:0]        mem [TABLE_DEPTH];
   logic [DATA_W-1:0]        rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;

   ise_state_type            state_ff, state_in;
   logic [SIZE_W-1:0]        size_ff, size_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         p_ff, p_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] tl_ff, tl_in;
   logic [IDX_W-1:0]         span_ff, span_in;
   logic [DATA_W-1:0]        dkey_ff, dkey_in;
   logic [NUM_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         dsr_ff, dsr_in;
   logic [IDX_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     res_found_ff, res_found_in;
   logic [IDX_W-1:0]         res_index_ff, res_index_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;

   logic                     req_fire;
   logic signed [DATA_W-1:0] cur;
   logic [DATA_W:0]          diff_key;
   logic [DATA_W:0]          diff_end;
   logic [IDX_W-1:0]         probe;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.found_index = rsp_index_ff;

   assign req_fire = req_ch.valid && (state_ff == ST_IDLE);
   assign wr_en    = req_fire && (req_ch.req_type == REQ_WRITE);
   assign cur      = $signed(rd_data_ff);
   assign diff_key = {key_ff[DATA_W-1], key_ff} - {tl_ff[DATA_W-1], tl_ff};
   assign diff_end = {cur[DATA_W-1], cur} - {tl_ff[DATA_W-1], tl_ff};
   assign probe    = lo_ff + quo_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[req_ch.entry_index] <= req_ch.entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p_in         = p_ff;
      key_in       = key_ff;
      tl_in        = tl_ff;
      span_in      = span_ff;
      dkey_in      = dkey_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_found_in = res_found_ff;
      res_index_in = res_index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rd_addr      = lo_ff;

      if (csr_ch.valid) begin
         size_in = csr_ch.table_size;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.req_type == REQ_SEARCH)) begin
               key_in       = req_ch.search_key;
               lo_in        = '0;
               res_found_in = 1'b0;
               res_index_in = '0;
               if (size_ff >= SIZE_W'(TABLE_DEPTH)) begin
                  hi_in = IDX_W'(TABLE_DEPTH - 1);
               end else begin
                  hi_in = IDX_W'(size_ff - SIZE_W'(1));
               end
               state_in = (size_ff == '0) ? ST_DONE : ST_READ_LO;
            end
         end
         ST_READ_LO: begin
            rd_addr  = lo_ff;
            state_in = ST_READ_HI;
         end
         ST_READ_HI: begin
            rd_addr  = hi_ff;
            tl_in    = cur;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // cur holds t[hi] here
            span_in = hi_ff - lo_ff;
            dkey_in = diff_key[DATA_W-1:0];
            dsr_in  = NUM_W'(diff_end[DATA_W-1:0]) << (IDX_W - 1);
            if ((key_ff < tl_ff) || (key_ff > cur)) begin
               state_in = ST_DONE;
            end else if ((lo_ff == hi_ff) || (tl_ff == cur)) begin
               res_found_in = (tl_ff == key_ff);
               res_index_in = (tl_ff == key_ff) ? lo_ff : '0;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in   = NUM_W'(span_ff) * NUM_W'(dkey_ff);
            quo_in   = '0;
            cnt_in   = CNT_W'(IDX_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // quotient never exceeds hi-lo, so IDX_W steps suffice
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               quo_in = {quo_ff[IDX_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[IDX_W-2:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            rd_addr  = probe;
            p_in     = probe;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (cur == key_ff) begin
               res_found_in = 1'b1;
               res_index_in = p_ff;
               state_in     = ST_DONE;
            end else if (cur < key_ff) begin
               if (p_ff == hi_ff) begin
                  state_in = ST_DONE;
               end else begin
                  lo_in    = p_ff + IDX_W'(1);
                  state_in = ST_READ_LO;
               end
            end else begin
               if (p_ff == lo_ff) begin
                  state_in = ST_DONE;
               end else begin
                  hi_in    = p_ff - IDX_W'(1);
                  state_in = ST_READ_LO;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_index_in = res_index_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      p_ff         <= p_in;
      key_ff       <= key_in;
      tl_ff        <= tl_in;
      span_ff      <= span_in;
      dkey_ff      <= dkey_in;
      rem_ff       <= rem_in;
      dsr_ff       <= dsr_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   `ISE_ASSERT_IMPLY(a_probe_in_window, state_ff == ST_COMPARE, (p_ff >= lo_ff) && (p_ff <= hi_ff))
   `ISE_ASSERT_IMPLY(a_window_valid, state_ff == ST_READ_LO, lo_ff <= hi_ff)
   `ISE_ASSERT_NEXT(a_search_starts, req_fire && (req_ch.req_type == REQ_SEARCH), state_ff != ST_IDLE)

endmodule
